// ===== hw/rtl/irc_format_code_parser_defines.svh =====
// Assertion helpers for the IRC format code parser.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef IRC_FORMAT_CODE_PARSER_DEFINES_SVH
`define IRC_FORMAT_CODE_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge out of reset
`define IFCP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset
`define IFCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IFCP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define IFCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/ifcp_pkg.sv =====
`default_nettype none

package ifcp_pkg;

    // Default text length limit, in bytes
    localparam int unsigned MAX_TEXT_BYTES_DEF = 65535;

    // Events that one byte can produce
    localparam int unsigned MAX_EVENTS = 4;
    localparam int unsigned EV_CNT_W   = $clog2(MAX_EVENTS + 1);
    localparam int unsigned EV_IDX_W   = $clog2(MAX_EVENTS);

    // Position field width on the event port
    localparam int unsigned POS_OUT_W = 16;

    // Formatting control bytes
    localparam logic [7:0] FMT_BOLD    = 8'h02;
    localparam logic [7:0] FMT_COLOUR  = 8'h03;
    localparam logic [7:0] FMT_HIDDEN  = 8'h08;
    localparam logic [7:0] FMT_NEWLINE = 8'h0A;
    localparam logic [7:0] FMT_RESET   = 8'h0F;
    localparam logic [7:0] FMT_REVERSE = 8'h16;
    localparam logic [7:0] FMT_ITALIC  = 8'h1D;
    localparam logic [7:0] FMT_STRIKE  = 8'h1E;
    localparam logic [7:0] FMT_UNDER   = 8'h1F;

    // Characters inside a colour code
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef logic [POS_OUT_W-1:0] pos16_t;
    typedef logic signed [7:0]    idx_t;

    // Palette index meaning "default colour"
    localparam idx_t IDX_DEFAULT = -8'sd1;

    typedef enum logic [2:0] {
        KIND_HIDE    = 3'd0,
        KIND_BOLD    = 3'd1,
        KIND_ITALIC  = 3'd2,
        KIND_STRIKE  = 3'd3,
        KIND_UNDER   = 3'd4,
        KIND_COLOURS = 3'd5,
        KIND_REVERSE = 3'd6,
        KIND_RESET   = 3'd7
    } kind_t;

    // Colour code parser position, one-hot
    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_FG0   = 6'b000010,
        PH_FG1   = 6'b000100,
        PH_BG0   = 6'b001000,
        PH_BG1   = 6'b010000,
        PH_FLUSH = 6'b100000
    } phase_t;

    // Up to two decimal digits of one palette index
    typedef struct packed {
        logic       hi_vld;
        logic [3:0] hi;
        logic       lo_vld;
        logic [3:0] lo;
    } digits_t;

    typedef struct packed {
        kind_t  kind;
        pos16_t start_pos;
        pos16_t end_pos;
        logic   style_on;
        idx_t   fg_index;
        idx_t   bg_index;
    } event_t;

    function automatic event_t make_event(kind_t kind, pos16_t s, pos16_t e, logic on,
                                          idx_t fg, idx_t bg);
        event_t ev;
        ev.kind      = kind;
        ev.start_pos = s;
        ev.end_pos   = e;
        ev.style_on  = on;
        ev.fg_index  = fg;
        ev.bg_index  = bg;
        return ev;
    endfunction

    // Palette index from parsed digits; no digits means the default
    function automatic idx_t digit_value(digits_t d);
        idx_t v;
        v = IDX_DEFAULT;
        if (d.hi_vld)
        begin
            if (d.lo_vld)
                v = $signed({1'b0, d.hi, 3'b000}) + $signed({3'b000, d.hi, 1'b0})
                    + $signed({4'b0000, d.lo});
            else
                v = $signed({4'b0000, d.hi});
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/irc_format_code_parser.sv =====
// IRC format code parser. Text bytes enter one beat at a time on in_valid/in_stall, with
// is_final on the last byte of a text; styling events leave one beat at a time on
// out_valid/out_stall, and last_of_run marks the final event of a byte. A byte is held in an
// input register, parsed there in one pass, and its events (none to four) are loaded into a
// four-entry event register that shifts out one event per cycle while out_stall is low;
// bytes with no events run at one byte per cycle, and a toggle inside a pending colour code
// causes four. Each byte passes the input register, then the event register. The next byte
// is accepted while the events of the previous one drain. parse_enable (reset 1) is written
// with cfg_wr_en/cfg_wr_data; the user must do so only while idle, which the block does not
// enforce. With it low, bytes are only counted. Bytes beyond MAX_TEXT_BYTES are dropped
// without events until the final byte, which always returns the parser to its reset state.
`default_nettype none

`include "irc_format_code_parser_defines.svh"

module irc_format_code_parser #(
    parameter int unsigned MAX_TEXT_BYTES = ifcp_pkg::MAX_TEXT_BYTES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_wr_data,
    // byte input
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [7:0]          text_byte,
    input  wire logic                is_final,
    // event output
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [2:0]               event_kind,
    output logic [15:0]              start_pos,
    output logic [15:0]              end_pos,
    output logic                     style_on,
    output logic signed [7:0]        fg_index,
    output logic signed [7:0]        bg_index,
    output logic                     last_of_run
);

    localparam int unsigned POS_W = $clog2(MAX_TEXT_BYTES + 1);
    localparam int unsigned EXT_W = (POS_W > ifcp_pkg::POS_OUT_W) ? POS_W
                                                                  : ifcp_pkg::POS_OUT_W;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_TEXT_BYTES);

    // configuration
    logic parse_enable_reg;

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] text_byte_reg;
    logic [7:0] text_byte_next;
    logic       fin_reg;
    logic       fin_next;
    logic       in_fire;

    // parser state
    logic                 bold_reg,      bold_next;
    logic                 italic_reg,    italic_next;
    logic                 underline_reg, underline_next;
    logic                 strike_reg,    strike_next;
    ifcp_pkg::phase_t     phase_reg,     phase_next;
    ifcp_pkg::digits_t    fg_reg,        fg_next;
    ifcp_pkg::digits_t    bg_reg,        bg_next;
    ifcp_pkg::pos16_t     span_reg,      span_next;
    logic                 after_comma_reg, after_comma_next;
    logic [POS_W-1:0]     pos_reg,       pos_next;
    logic [EXT_W-1:0]     pos_ext;

    // events of the byte in the input register
    ifcp_pkg::event_t             ev_new [ifcp_pkg::MAX_EVENTS];
    logic [ifcp_pkg::EV_CNT_W-1:0] ev_cnt_new;

    // event register
    ifcp_pkg::event_t              ev_reg  [ifcp_pkg::MAX_EVENTS];
    ifcp_pkg::event_t              ev_next [ifcp_pkg::MAX_EVENTS];
    logic [ifcp_pkg::EV_CNT_W-1:0] cnt_reg;
    logic [ifcp_pkg::EV_CNT_W-1:0] cnt_next;
    logic                          out_fire;
    logic                          take;

    assign pos_ext = EXT_W'(pos_reg);

    // Handshake: the held byte moves into the event register once it is empty or emptying
    assign out_valid = (cnt_reg != '0);
    assign out_fire  = out_valid && !out_stall;
    assign take      = in_valid_reg
                       && ((cnt_reg == '0)
                           || ((cnt_reg == ifcp_pkg::EV_CNT_W'(1)) && !out_stall));
    assign in_stall  = in_valid_reg && !take;
    assign in_fire   = in_valid && !in_stall;

    // Input register next values
    always_comb
    begin
        in_valid_next  = in_fire || (in_valid_reg && !take);
        text_byte_next = in_fire ? text_byte : text_byte_reg;
        fin_next       = in_fire ? is_final : fin_reg;
    end

    // Parse the held byte: events and next parser state
    always_comb
    begin : proc_parse
        logic             digit;
        logic             do_check;
        logic             flush;
        logic             pos_active;
        ifcp_pkg::pos16_t cur_pos;
        ifcp_pkg::pos16_t nxt_pos;
        ifcp_pkg::pos16_t hide_start;
        ifcp_pkg::pos16_t hide_end;

        bold_next        = bold_reg;
        italic_next      = italic_reg;
        underline_next   = underline_reg;
        strike_next      = strike_reg;
        phase_next       = phase_reg;
        fg_next          = fg_reg;
        bg_next          = bg_reg;
        span_next        = span_reg;
        after_comma_next = after_comma_reg;
        pos_next         = pos_reg;
        for (int i = 0; i < ifcp_pkg::MAX_EVENTS; i++)
            ev_new[i] = '0;
        ev_cnt_new = '0;

        digit      = (text_byte_reg >= ifcp_pkg::CHAR_ZERO)
                     && (text_byte_reg <= ifcp_pkg::CHAR_NINE);
        do_check   = 1'b0;
        flush      = 1'b0;
        pos_active = (pos_reg < MAX_POS);
        cur_pos    = pos_ext[ifcp_pkg::POS_OUT_W-1:0];
        nxt_pos    = cur_pos + 16'd1;
        hide_start = '0;
        hide_end   = '0;

        if (pos_active)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (parse_enable_reg)
            begin
                // control code's own events
                case (text_byte_reg)
                    ifcp_pkg::FMT_BOLD:
                    begin
                        ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                            ifcp_pkg::KIND_HIDE, cur_pos, nxt_pos, 1'b0, '0, '0);
                        ev_cnt_new = ev_cnt_new + 3'd1;
                        bold_next = !bold_reg;
                        ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                            ifcp_pkg::KIND_BOLD, cur_pos, '0, !bold_reg, '0, '0);
                        ev_cnt_new = ev_cnt_new + 3'd1;
                        do_check = 1'b1;
                    end
                    ifcp_pkg::FMT_ITALIC:
                    begin
                        ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                            ifcp_pkg::KIND_HIDE, cur_pos, nxt_pos, 1'b0, '0, '0);
                        ev_cnt_new = ev_cnt_new + 3'd1;
                        italic_next = !italic_reg;
                        ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                            ifcp_pkg::KIND_ITALIC, cur_pos, '0, !italic_reg, '0, '0);
                        ev_cnt_new = ev_cnt_new + 3'd1;
                        do_check = 1'b1;
                    end
                    ifcp_pkg::FMT_STRIKE:
                    begin
                        ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                            ifcp_pkg::KIND_HIDE, cur_pos, nxt_pos, 1'b0, '0, '0);
                        ev_cnt_new = ev_cnt_new + 3'd1;
                        strike_next = !strike_reg;
                        ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                            ifcp_pkg::KIND_STRIKE, cur_pos, '0, !strike_reg, '0, '0);
                        ev_cnt_new = ev_cnt_new + 3'd1;
                        do_check = 1'b1;
                    end
                    ifcp_pkg::FMT_UNDER:
                    begin
                        ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                            ifcp_pkg::KIND_HIDE, cur_pos, nxt_pos, 1'b0, '0, '0);
                        ev_cnt_new = ev_cnt_new + 3'd1;
                        underline_next = !underline_reg;
                        ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                            ifcp_pkg::KIND_UNDER, cur_pos, '0, !underline_reg, '0, '0);
                        ev_cnt_new = ev_cnt_new + 3'd1;
                        do_check = 1'b1;
                    end
                    ifcp_pkg::FMT_RESET:
                    begin
                        ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                            ifcp_pkg::KIND_HIDE, cur_pos, nxt_pos, 1'b0, '0, '0);
                        ev_cnt_new = ev_cnt_new + 3'd1;
                        ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                            ifcp_pkg::KIND_RESET, cur_pos, '0, 1'b0,
                            ifcp_pkg::IDX_DEFAULT, ifcp_pkg::IDX_DEFAULT);
                        ev_cnt_new = ev_cnt_new + 3'd1;
                        bold_next      = 1'b0;
                        italic_next    = 1'b0;
                        underline_next = 1'b0;
                        strike_next    = 1'b0;
                        do_check = 1'b1;
                    end
                    ifcp_pkg::FMT_HIDDEN:
                    begin
                        ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                            ifcp_pkg::KIND_HIDE, cur_pos, nxt_pos, 1'b0, '0, '0);
                        ev_cnt_new = ev_cnt_new + 3'd1;
                        do_check = 1'b1;
                    end
                    ifcp_pkg::FMT_REVERSE:
                    begin
                        ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                            ifcp_pkg::KIND_HIDE, cur_pos, nxt_pos, 1'b0, '0, '0);
                        ev_cnt_new = ev_cnt_new + 3'd1;
                        ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                            ifcp_pkg::KIND_REVERSE, cur_pos, '0, 1'b0, '0, '0);
                        ev_cnt_new = ev_cnt_new + 3'd1;
                        do_check = 1'b1;
                    end
                    ifcp_pkg::FMT_NEWLINE:
                    begin
                        // reset, and a pending colour code is dropped silently
                        ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                            ifcp_pkg::KIND_RESET, cur_pos, '0, 1'b0,
                            ifcp_pkg::IDX_DEFAULT, ifcp_pkg::IDX_DEFAULT);
                        ev_cnt_new = ev_cnt_new + 3'd1;
                        bold_next      = 1'b0;
                        italic_next    = 1'b0;
                        underline_next = 1'b0;
                        strike_next    = 1'b0;
                        phase_next     = ifcp_pkg::PH_IDLE;
                        span_next      = '0;
                        fg_next        = '0;
                        bg_next        = '0;
                    end
                    ifcp_pkg::FMT_COLOUR:
                    begin
                        // starts a colour code, discarding any pending one
                        ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                            ifcp_pkg::KIND_HIDE, cur_pos, nxt_pos, 1'b0, '0, '0);
                        ev_cnt_new = ev_cnt_new + 3'd1;
                        phase_next = ifcp_pkg::PH_FG0;
                        span_next  = 16'd1;
                        fg_next    = '0;
                        bg_next    = '0;
                    end
                    default:
                    begin
                        do_check = 1'b1;
                    end
                endcase

                // colour code digits, comma, or end of the code
                if (do_check && (phase_reg != ifcp_pkg::PH_IDLE))
                begin
                    if (!digit && (text_byte_reg == ifcp_pkg::CHAR_COMMA)
                        && ((phase_reg == ifcp_pkg::PH_FG0) || (phase_reg == ifcp_pkg::PH_FG1)
                            || (phase_reg == ifcp_pkg::PH_BG0)))
                    begin
                        phase_next = ifcp_pkg::PH_BG0;
                        span_next  = span_reg + 16'd1;
                    end
                    else if (!digit || ((phase_reg == ifcp_pkg::PH_BG0) && !after_comma_reg))
                    begin
                        flush = 1'b1;
                    end
                    else
                    begin
                        span_next = span_reg + 16'd1;
                        case (phase_reg)
                            ifcp_pkg::PH_FG0:
                            begin
                                fg_next.hi_vld = 1'b1;
                                fg_next.hi     = text_byte_reg[3:0];
                                phase_next     = ifcp_pkg::PH_FG1;
                            end
                            ifcp_pkg::PH_FG1:
                            begin
                                fg_next.lo_vld = 1'b1;
                                fg_next.lo     = text_byte_reg[3:0];
                                phase_next     = ifcp_pkg::PH_BG0;
                            end
                            ifcp_pkg::PH_BG0:
                            begin
                                bg_next.hi_vld = 1'b1;
                                bg_next.hi     = text_byte_reg[3:0];
                                phase_next     = ifcp_pkg::PH_BG1;
                            end
                            ifcp_pkg::PH_BG1:
                            begin
                                bg_next.lo_vld = 1'b1;
                                bg_next.lo     = text_byte_reg[3:0];
                                phase_next     = ifcp_pkg::PH_FLUSH;
                            end
                            default:
                            begin
                                flush = 1'b1;
                            end
                        endcase
                    end

                    // end of the code: hide it and report its colours here
                    if (flush)
                    begin
                        hide_start = cur_pos - span_reg;
                        hide_end   = (fg_reg.hi_vld || bg_reg.hi_vld) ? cur_pos
                                                                      : hide_start + 16'd1;
                        ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                            ifcp_pkg::KIND_HIDE, hide_start, hide_end, 1'b0, '0, '0);
                        ev_cnt_new = ev_cnt_new + 3'd1;
                        ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                            ifcp_pkg::KIND_COLOURS, cur_pos, '0, 1'b0,
                            ifcp_pkg::digit_value(fg_reg), ifcp_pkg::digit_value(bg_reg));
                        ev_cnt_new = ev_cnt_new + 3'd1;
                        phase_next = ifcp_pkg::PH_IDLE;
                        span_next  = '0;
                        fg_next    = '0;
                        bg_next    = '0;
                    end
                end

                after_comma_next = (text_byte_reg == ifcp_pkg::CHAR_COMMA);

                // last byte with a code still open: report it at the text end
                if (fin_reg && (phase_next != ifcp_pkg::PH_IDLE))
                begin
                    if (fg_next.hi_vld || bg_next.hi_vld)
                    begin
                        ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                            ifcp_pkg::KIND_HIDE, nxt_pos - span_next, nxt_pos, 1'b0, '0, '0);
                        ev_cnt_new = ev_cnt_new + 3'd1;
                    end
                    ev_new[ev_cnt_new[ifcp_pkg::EV_IDX_W-1:0]] = ifcp_pkg::make_event(
                        ifcp_pkg::KIND_COLOURS, nxt_pos, '0, 1'b0,
                        ifcp_pkg::digit_value(fg_next), ifcp_pkg::digit_value(bg_next));
                    ev_cnt_new = ev_cnt_new + 3'd1;
                end
            end
        end

        // final byte returns everything to reset
        if (fin_reg)
        begin
            bold_next        = 1'b0;
            italic_next      = 1'b0;
            underline_next   = 1'b0;
            strike_next      = 1'b0;
            phase_next       = ifcp_pkg::PH_IDLE;
            span_next        = '0;
            fg_next          = '0;
            bg_next          = '0;
            after_comma_next = 1'b0;
            pos_next         = '0;
        end
    end

    // Event register: load a new run or shift the head out
    always_comb
    begin
        for (int i = 0; i < ifcp_pkg::MAX_EVENTS; i++)
            ev_next[i] = ev_reg[i];
        cnt_next = cnt_reg;
        if (take)
        begin
            for (int i = 0; i < ifcp_pkg::MAX_EVENTS; i++)
                ev_next[i] = ev_new[i];
            cnt_next = ev_cnt_new;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < ifcp_pkg::MAX_EVENTS - 1; i++)
                ev_next[i] = ev_reg[i + 1];
            cnt_next = cnt_reg - ifcp_pkg::EV_CNT_W'(1);
        end
    end

    // Control and parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_enable_reg <= 1'b1;
            in_valid_reg     <= 1'b0;
            cnt_reg          <= '0;
            bold_reg         <= 1'b0;
            italic_reg       <= 1'b0;
            underline_reg    <= 1'b0;
            strike_reg       <= 1'b0;
            phase_reg        <= ifcp_pkg::PH_IDLE;
            fg_reg           <= '0;
            bg_reg           <= '0;
            span_reg         <= '0;
            after_comma_reg  <= 1'b0;
            pos_reg          <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                parse_enable_reg <= cfg_wr_data;
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
            if (take)
            begin
                bold_reg        <= bold_next;
                italic_reg      <= italic_next;
                underline_reg   <= underline_next;
                strike_reg      <= strike_next;
                phase_reg       <= phase_next;
                fg_reg          <= fg_next;
                bg_reg          <= bg_next;
                span_reg        <= span_next;
                after_comma_reg <= after_comma_next;
                pos_reg         <= pos_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        text_byte_reg <= text_byte_next;
        fin_reg       <= fin_next;
        for (int i = 0; i < ifcp_pkg::MAX_EVENTS; i++)
            ev_reg[i] <= ev_next[i];
    end

    // Event port driven from the head of the event register
    assign event_kind  = ev_reg[0].kind;
    assign start_pos   = ev_reg[0].start_pos;
    assign end_pos     = ev_reg[0].end_pos;
    assign style_on    = ev_reg[0].style_on;
    assign fg_index    = ev_reg[0].fg_index;
    assign bg_index    = ev_reg[0].bg_index;
    assign last_of_run = (cnt_reg == ifcp_pkg::EV_CNT_W'(1));

    // Checks
    `IFCP_ASSERT_IMPLY(a_span_idle, clk, rst_n, phase_reg == ifcp_pkg::PH_IDLE, span_reg == '0, "colour span left over with no open code")
    `IFCP_ASSERT_IMPLY(a_digits_idle, clk, rst_n, phase_reg == ifcp_pkg::PH_IDLE, !fg_reg.hi_vld && !bg_reg.hi_vld, "colour digits left over with no open code")
    `IFCP_ASSERT_NEXT(a_run_continues, clk, rst_n, out_fire && !last_of_run, out_valid, "event run cut short")
    `IFCP_ASSERT_NEXT(a_final_clears, clk, rst_n, take && fin_reg, pos_reg == '0 && phase_reg == ifcp_pkg::PH_IDLE, "final byte did not clear state")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;
    import ifcp_pkg::*;

    localparam int CYCLE_LIMIT = 50000;
    // idle cycles after the last event before touching the register
    localparam int LAT_IDLE = 8;

    // colour code digit slots
    localparam int unsigned SLOT_NONE  = 0;
    localparam int unsigned SLOT_FG0   = 1;
    localparam int unsigned SLOT_FG1   = 2;
    localparam int unsigned SLOT_BG0   = 3;
    localparam int unsigned SLOT_BG1   = 4;
    localparam int unsigned SLOT_FLUSH = 5;

    typedef struct packed {
        kind_t  kind;
        pos16_t start_pos;
        pos16_t end_pos;
        logic   style_on;
        idx_t   fg_index;
        idx_t   bg_index;
        logic   last_of_run;
    } ev_rec_t;

    // Tracks the parser state and holds the events still owed by the block
    class format_event_board;
        ev_rec_t     expect_q[$];
        ev_rec_t     byte_evs[$];
        int          errors;
        bit          enable;
        bit          bold_on, italic_on, under_on, strike_on;
        int unsigned slot;
        logic [7:0]  fg_d [2];
        logic [7:0]  bg_d [2];
        int unsigned span;
        bit          prev_comma;
        int unsigned pos;

        function new();
            enable = 1;
            errors = 0;
            clear_text();
        endfunction

        function void clear_colour();
            slot = SLOT_NONE;
            span = 0;
            fg_d[0] = 8'h00;
            fg_d[1] = 8'h00;
            bg_d[0] = 8'h00;
            bg_d[1] = 8'h00;
        endfunction

        function void clear_text();
            bold_on = 0;
            italic_on = 0;
            under_on = 0;
            strike_on = 0;
            clear_colour();
            prev_comma = 0;
            pos = 0;
        endfunction

        // two ASCII digits to a palette index, no digit gives the default
        function idx_t palette(logic [7:0] hi, logic [7:0] lo);
            int v;
            if (hi == 8'h00)
                return IDX_DEFAULT;
            v = hi - CHAR_ZERO;
            if (lo != 8'h00)
                v = v * 10 + (lo - CHAR_ZERO);
            return idx_t'(v);
        endfunction

        function void add_ev(kind_t k, int unsigned s, int unsigned e, bit on,
                             idx_t fg, idx_t bg);
            ev_rec_t r;
            r.kind        = k;
            r.start_pos   = pos16_t'(s);
            r.end_pos     = pos16_t'(e);
            r.style_on    = on;
            r.fg_index    = fg;
            r.bg_index    = bg;
            r.last_of_run = 1'b0;
            byte_evs.push_back(r);
        endfunction

        function void toggle_ev(kind_t k, bit on, int unsigned p);
            add_ev(KIND_HIDE, p, p + 1, 0, 0, 0);
            add_ev(k, p, 0, on, 0, 0);
        endfunction

        // advance a pending colour code by one byte
        function void colour_step(logic [7:0] b, int unsigned p);
            bit          is_digit;
            int unsigned s;
            is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
            if (slot == SLOT_NONE)
                return;
            if (!is_digit)
            begin
                if (b == CHAR_COMMA && slot <= SLOT_BG0)
                begin
                    slot = SLOT_BG0;
                    span++;
                    return;
                end
                slot = SLOT_FLUSH;
            end
            else if (slot == SLOT_BG0 && !prev_comma)
                slot = SLOT_FLUSH;
            case (slot)
                SLOT_FG0: fg_d[0] = b;
                SLOT_FG1: fg_d[1] = b;
                SLOT_BG0: bg_d[0] = b;
                SLOT_BG1: bg_d[1] = b;
                default:
                begin
                    // code ends here: hide its bytes, then apply the colours
                    s = p - span;
                    if (fg_d[0] != 8'h00 || bg_d[0] != 8'h00)
                        add_ev(KIND_HIDE, s, p, 0, 0, 0);
                    else
                        add_ev(KIND_HIDE, s, s + 1, 0, 0, 0);
                    add_ev(KIND_COLOURS, p, 0, 0, palette(fg_d[0], fg_d[1]),
                           palette(bg_d[0], bg_d[1]));
                    clear_colour();
                    return;
                end
            endcase
            slot++;
            span++;
        endfunction

        // predict the events of one accepted byte beat
        function void note_byte(logic [7:0] b, bit fin);
            int unsigned p;
            int unsigned len;
            byte_evs.delete();
            p = pos;
            if (p < MAX_TEXT_BYTES_DEF)
            begin
                pos = p + 1;
                if (enable)
                begin
                    case (b)
                        FMT_BOLD:
                        begin
                            bold_on = !bold_on;
                            toggle_ev(KIND_BOLD, bold_on, p);
                            colour_step(b, p);
                        end
                        FMT_ITALIC:
                        begin
                            italic_on = !italic_on;
                            toggle_ev(KIND_ITALIC, italic_on, p);
                            colour_step(b, p);
                        end
                        FMT_STRIKE:
                        begin
                            strike_on = !strike_on;
                            toggle_ev(KIND_STRIKE, strike_on, p);
                            colour_step(b, p);
                        end
                        FMT_UNDER:
                        begin
                            under_on = !under_on;
                            toggle_ev(KIND_UNDER, under_on, p);
                            colour_step(b, p);
                        end
                        FMT_RESET:
                        begin
                            add_ev(KIND_HIDE, p, p + 1, 0, 0, 0);
                            add_ev(KIND_RESET, p, 0, 0, IDX_DEFAULT, IDX_DEFAULT);
                            bold_on = 0; italic_on = 0; under_on = 0; strike_on = 0;
                            colour_step(b, p);
                        end
                        FMT_HIDDEN:
                        begin
                            add_ev(KIND_HIDE, p, p + 1, 0, 0, 0);
                            colour_step(b, p);
                        end
                        FMT_REVERSE:
                        begin
                            add_ev(KIND_HIDE, p, p + 1, 0, 0, 0);
                            add_ev(KIND_REVERSE, p, 0, 0, 0, 0);
                            colour_step(b, p);
                        end
                        FMT_NEWLINE:
                        begin
                            // drops a pending colour code silently
                            add_ev(KIND_RESET, p, 0, 0, IDX_DEFAULT, IDX_DEFAULT);
                            bold_on = 0; italic_on = 0; under_on = 0; strike_on = 0;
                            clear_colour();
                        end
                        FMT_COLOUR:
                        begin
                            // a new code discards any earlier digits
                            add_ev(KIND_HIDE, p, p + 1, 0, 0, 0);
                            clear_colour();
                            slot = SLOT_FG0;
                            span = 1;
                        end
                        default:
                            colour_step(b, p);
                    endcase
                    prev_comma = (b == CHAR_COMMA);
                    // end of text flushes a code still open
                    if (fin && slot != SLOT_NONE)
                    begin
                        len = p + 1;
                        if (fg_d[0] != 8'h00 || bg_d[0] != 8'h00)
                            add_ev(KIND_HIDE, len - span, len, 0, 0, 0);
                        add_ev(KIND_COLOURS, len, 0, 0, palette(fg_d[0], fg_d[1]),
                               palette(bg_d[0], bg_d[1]));
                    end
                end
            end
            if (fin)
                clear_text();
            if (byte_evs.size() > 0)
                byte_evs[byte_evs.size() - 1].last_of_run = 1'b1;
            foreach (byte_evs[i])
                expect_q.push_back(byte_evs[i]);
        endfunction

        function string show(ev_rec_t r);
            return $sformatf("kind=%0d start=%0d end=%0d on=%0b fg=%0d bg=%0d last=%0b",
                             r.kind, r.start_pos, r.end_pos, r.style_on, r.fg_index,
                             r.bg_index, r.last_of_run);
        endfunction

        // compare one event beat with the oldest expected one
        function void check_event(ev_rec_t got);
            ev_rec_t want;
            if (expect_q.size() == 0)
            begin
                if (errors < 200)
                    $display("%0t: event with none expected, got %s", $time, show(got));
                errors++;
                return;
            end
            want = expect_q.pop_front();
            if (got.kind !== want.kind || got.start_pos !== want.start_pos ||
                got.end_pos !== want.end_pos || got.style_on !== want.style_on ||
                got.fg_index !== want.fg_index || got.bg_index !== want.bg_index ||
                got.last_of_run !== want.last_of_run)
            begin
                if (errors < 200)
                    $display("%0t: expected %s, got %s", $time, show(want), show(got));
                errors++;
            end
        endfunction

        function int pending();
            return expect_q.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic              cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        text_byte;
    logic              is_final;
    logic              out_valid;
    logic              out_stall;
    logic [2:0]        event_kind;
    logic [15:0]       start_pos;
    logic [15:0]       end_pos;
    logic              style_on;
    logic signed [7:0] fg_index;
    logic signed [7:0] bg_index;
    logic              last_of_run;

    format_event_board sb;
    ev_rec_t           seen_ev;
    int                cycle_count = 0;
    int                burst_left = 0;
    int                stall_left = 0;
    int                stall_mode = 0;
    int                sent;
    logic [7:0]        text_q[$];

    logic [7:0] toggle_codes [4] = '{FMT_BOLD, FMT_ITALIC, FMT_STRIKE, FMT_UNDER};
    logic [7:0] ctrl_codes [4]   = '{FMT_RESET, FMT_HIDDEN, FMT_REVERSE, FMT_NEWLINE};
    int         enable_plan [6]  = '{1, 0, 1, 1, 0, 1};

    // every toggle and control, a full colour code, a toggle inside a code,
    // a restarted code, background only, newline dropping a code, final flush
    logic [7:0] directed_seq [25] = '{
        FMT_BOLD, FMT_ITALIC, FMT_STRIKE, FMT_UNDER, FMT_RESET, FMT_HIDDEN, FMT_REVERSE,
        FMT_COLOUR, 8'h31, 8'h32, CHAR_COMMA, 8'h33, 8'h34, FMT_BOLD,
        FMT_COLOUR, 8'h37, FMT_COLOUR, CHAR_COMMA, 8'h39, 8'h7A,
        FMT_COLOUR, 8'h35, FMT_NEWLINE, FMT_COLOUR, 8'h36
    };

    irc_format_code_parser u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_byte   (text_byte),
        .is_final    (is_final),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .start_pos   (start_pos),
        .end_pos     (end_pos),
        .style_on    (style_on),
        .fg_index    (fg_index),
        .bg_index    (bg_index),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // run limit
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("irc_format_code_parser: mismatch");
        $finish;
    end

    // receiver stall pattern: random modes, each held for a random stretch
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 80);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (stall_left % 3 == 0);
        endcase
    end

    // event beats
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_ev.kind        = kind_t'(event_kind);
            seen_ev.start_pos   = start_pos;
            seen_ev.end_pos     = end_pos;
            seen_ev.style_on    = style_on;
            seen_ev.fg_index    = fg_index;
            seen_ev.bg_index    = bg_index;
            seen_ev.last_of_run = last_of_run;
            sb.check_event(seen_ev);
        end
    end

    function automatic logic [7:0] rand_digit();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // one byte beat, held until accepted
    task send_byte(input logic [7:0] b, input bit fin);
        text_byte <= b;
        is_final  <= fin;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(b, fin);
    endtask

    task pause_in(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // byte beats in bursts with random gaps in between
    task feed_byte(input logic [7:0] b, input bit fin);
        if (burst_left == 0)
        begin
            pause_in($urandom_range(0, 6));
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        send_byte(b, fin);
    endtask

    // stop sending until every owed event is out, then let the pipe settle
    task drain_events();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LAT_IDLE) @(posedge clk);
    endtask

    task write_enable(input bit v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.enable = v;
    endtask

    // mostly well-formed codes with random content, some noise
    task build_text();
        int target;
        int n;
        text_q.delete();
        target = $urandom_range(1, 14);
        while (text_q.size() < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    text_q.push_back(FMT_COLOUR);
                    n = $urandom_range(0, 2);
                    repeat (n) text_q.push_back(rand_digit());
                    if ($urandom_range(0, 1) == 1)
                    begin
                        text_q.push_back(CHAR_COMMA);
                        n = $urandom_range(0, 2);
                        repeat (n) text_q.push_back(rand_digit());
                    end
                end
                3:       text_q.push_back(toggle_codes[$urandom_range(0, 3)]);
                4:       text_q.push_back(ctrl_codes[$urandom_range(0, 3)]);
                5, 6:    text_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
                7:       text_q.push_back(($urandom_range(0, 1) == 1) ? rand_digit() : CHAR_COMMA);
                8:       text_q.push_back(8'($urandom_range(0, 255)));
                default:
                begin
                    text_q.push_back(FMT_COLOUR);
                    text_q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
        while (text_q.size() > target)
            void'(text_q.pop_back());
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        in_valid    = 1'b0;
        text_byte   = 8'h00;
        is_final    = 1'b0;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed text
        write_enable(1'b1);
        foreach (directed_seq[i])
            feed_byte(directed_seq[i], i == 24);
        drain_events();

        // random texts under each register setting
        foreach (enable_plan[k])
        begin
            write_enable(enable_plan[k][0]);
            sent = 0;
            while (sent < 14)
            begin
                build_text();
                foreach (text_q[i])
                    feed_byte(text_q[i], i == text_q.size() - 1);
                sent += text_q.size();
                if ($urandom_range(0, 5) == 0)
                    drain_events();
            end
            drain_events();
        end

        if (sb.pending() != 0)
        begin
            $display("%0t: %0d events never arrived, oldest %s", $time, sb.pending(),
                     sb.show(sb.expect_q[0]));
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("irc_format_code_parser: match");
        else
            $display("irc_format_code_parser: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
